/* hw/rtl/assert_macros.svh */
// Assertion helpers included by signed_decimal_to_ascii.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, sampled on the rising clock edge, off during reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion that is checked during reset as well.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/sd2a_pkg.sv */
package sd2a_pkg;

    localparam int FIELD_CHARS = 12;
    localparam int NUM_DIGITS  = 10;
    localparam int VALUE_W     = 32;
    localparam int WIDTH_W     = 4;
    localparam int CHAR_W      = 7;
    localparam int BCD_W       = 4 * NUM_DIGITS;
    localparam int DD_STAGES   = 4;
    localparam int DD_BITS     = VALUE_W / DD_STAGES;
    localparam int IDX_W       = $clog2(FIELD_CHARS);
    localparam int NDIG_W      = $clog2(NUM_DIGITS + 1);
    localparam int IN_TDATA_W  = ((VALUE_W + WIDTH_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CHAR_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

    typedef enum logic {
        OP_MINIMAL = 1'b0,
        OP_FIXED   = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode              op;
        logic                 neg;
        logic [WIDTH_W-1:0]   width;
        logic [BCD_W-1:0]     bcd;
        logic [VALUE_W-1:0]   bin;
    } t_dd;

    typedef logic [FIELD_CHARS-1:0][CHAR_W-1:0] t_chars;

    // Runs DD_BITS steps of the shift-and-add-three binary to BCD conversion.
    function automatic t_dd dabble_step(input t_dd s);
        t_dd o;
        o = s;
        for (int step = 0; step < DD_BITS; step++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (o.bcd[4*d +: 4] >= 4'd5) begin
                    o.bcd[4*d +: 4] = o.bcd[4*d +: 4] + 4'd3;
                end
            end
            {o.bcd, o.bin} = {o.bcd, o.bin} << 1;
        end
        return o;
    endfunction

endpackage

/* hw/rtl/signed_decimal_to_ascii.sv */
// Converts a signed 32-bit value to decimal ASCII, one character per output
// transaction, most significant first, with tlast on the final character.
// tuser selects the form: 0 gives an optional minus sign and the digits,
// 1 gives the rightmost field_width characters (clamped to 1..12) of a
// zero-filled 12-character field with the minus sign just before the digits.
// A transaction passes an input register, four binary-to-BCD stages of eight
// bits each, a formatting register and an output register before its first
// character is presented.
// The single-character output port sets the rate: an item holds the output
// until all of its characters (1 to 12) are taken, and a next item waiting in
// the formatting register is loaded as the last character is taken.
module signed_decimal_to_ascii (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // Fields from bit 0: value[31:0], field_width[35:32], zero fill.
    input  logic [sd2a_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // Fields from bit 0: opcode.
    input  logic                               i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // Fields from bit 0: character[6:0], zero fill.
    output logic [sd2a_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                               o_m_axis_tlast
);

    logic                      r_s1_valid;
    sd2a_pkg::t_dd             r_s1;
    logic                      s1_ready;
    logic [sd2a_pkg::VALUE_W-1:0] in_value;

    logic                      r_dd_valid [sd2a_pkg::DD_STAGES];
    sd2a_pkg::t_dd             r_dd       [sd2a_pkg::DD_STAGES];
    logic                      dd_ready   [sd2a_pkg::DD_STAGES];

    logic                      r_fmt_valid;
    sd2a_pkg::t_chars          r_fmt_chars;
    logic [sd2a_pkg::IDX_W-1:0] r_fmt_idx;
    logic                      fmt_ready;
    sd2a_pkg::t_chars          n_fmt_chars;
    logic [sd2a_pkg::IDX_W-1:0] n_fmt_idx;
    logic [sd2a_pkg::NDIG_W-1:0] ndig;

    logic                      r_out_valid;
    sd2a_pkg::t_chars          r_out_chars;
    logic [sd2a_pkg::IDX_W-1:0] r_out_idx;
    logic                      out_free;
    logic                      out_fire;

    assign in_value = i_s_axis_tdata[sd2a_pkg::VALUE_W-1:0];

    assign out_fire = r_out_valid && i_m_axis_tready;
    assign out_free = !r_out_valid || (i_m_axis_tready && (r_out_idx == '0));
    assign fmt_ready = !r_fmt_valid || out_free;

    always_comb begin
        for (int k = sd2a_pkg::DD_STAGES - 1; k >= 0; k--) begin
            if (k == sd2a_pkg::DD_STAGES - 1) begin
                dd_ready[k] = !r_dd_valid[k] || fmt_ready;
            end else begin
                dd_ready[k] = !r_dd_valid[k] || dd_ready[k+1];
            end
        end
    end

    assign s1_ready = !r_s1_valid || dd_ready[0];
    assign o_s_axis_tready = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            for (int k = 0; k < sd2a_pkg::DD_STAGES; k++) begin
                r_dd_valid[k] <= 1'b0;
            end
            r_fmt_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_s_axis_tvalid;
            end
            for (int k = 0; k < sd2a_pkg::DD_STAGES; k++) begin
                if (dd_ready[k]) begin
                    r_dd_valid[k] <= (k == 0) ? r_s1_valid : r_dd_valid[(k == 0) ? 0 : k-1];
                end
            end
            if (fmt_ready) begin
                r_fmt_valid <= r_dd_valid[sd2a_pkg::DD_STAGES-1];
            end
            if (out_free) begin
                r_out_valid <= r_fmt_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_s_axis_tvalid) begin
            r_s1.op    <= sd2a_pkg::t_opcode'(i_s_axis_tuser);
            r_s1.neg   <= in_value[sd2a_pkg::VALUE_W-1];
            r_s1.width <= i_s_axis_tdata[sd2a_pkg::VALUE_W +: sd2a_pkg::WIDTH_W];
            r_s1.bcd   <= '0;
            r_s1.bin   <= in_value[sd2a_pkg::VALUE_W-1] ? (~in_value + 1'b1) : in_value;
        end
        for (int k = 0; k < sd2a_pkg::DD_STAGES; k++) begin
            if (k == 0) begin
                if (dd_ready[k] && r_s1_valid) begin
                    r_dd[k] <= sd2a_pkg::dabble_step(r_s1);
                end
            end else begin
                if (dd_ready[k] && r_dd_valid[k-1]) begin
                    r_dd[k] <= sd2a_pkg::dabble_step(r_dd[k-1]);
                end
            end
        end
        if (fmt_ready && r_dd_valid[sd2a_pkg::DD_STAGES-1]) begin
            r_fmt_chars <= n_fmt_chars;
            r_fmt_idx   <= n_fmt_idx;
        end
        if (out_free && r_fmt_valid) begin
            r_out_chars <= r_fmt_chars;
            r_out_idx   <= r_fmt_idx;
        end else if (out_fire) begin
            r_out_idx <= r_out_idx - 1'b1;
        end
    end

    // Characters are held by position from the right end of the field.
    always_comb begin
        sd2a_pkg::t_dd src;
        int            wi;
        src  = r_dd[sd2a_pkg::DD_STAGES-1];
        ndig = sd2a_pkg::NDIG_W'(1);
        for (int r = 0; r < sd2a_pkg::NUM_DIGITS; r++) begin
            if (src.bcd[4*r +: 4] != 4'd0) begin
                ndig = sd2a_pkg::NDIG_W'(r + 1);
            end
        end
        for (int r = 0; r < sd2a_pkg::FIELD_CHARS; r++) begin
            n_fmt_chars[r] = sd2a_pkg::CHAR_ZERO;
        end
        for (int r = 0; r < sd2a_pkg::NUM_DIGITS; r++) begin
            n_fmt_chars[r] = sd2a_pkg::CHAR_ZERO + sd2a_pkg::CHAR_W'(src.bcd[4*r +: 4]);
        end
        for (int r = 0; r < sd2a_pkg::FIELD_CHARS; r++) begin
            if (src.neg && (int'(ndig) == r)) begin
                n_fmt_chars[r] = sd2a_pkg::CHAR_MINUS;
            end
        end
        wi = int'(src.width);
        if (wi < 1) begin
            wi = 1;
        end
        if (wi > sd2a_pkg::FIELD_CHARS) begin
            wi = sd2a_pkg::FIELD_CHARS;
        end
        case (src.op)
            sd2a_pkg::OP_FIXED: begin
                n_fmt_idx = sd2a_pkg::IDX_W'(wi - 1);
            end
            default: begin
                n_fmt_idx = sd2a_pkg::IDX_W'(int'(ndig) - (src.neg ? 0 : 1));
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = sd2a_pkg::OUT_TDATA_W'(r_out_chars[r_out_idx]);
    assign o_m_axis_tlast  = (r_out_idx == '0);

`include "assert_macros.svh"

    `ASSERT_CLK(a_char_legal, i_clk, i_rst_n, o_m_axis_tvalid |-> ((o_m_axis_tdata[sd2a_pkg::CHAR_W-1:0] >= sd2a_pkg::CHAR_ZERO && o_m_axis_tdata[sd2a_pkg::CHAR_W-1:0] <= sd2a_pkg::CHAR_NINE) || o_m_axis_tdata[sd2a_pkg::CHAR_W-1:0] == sd2a_pkg::CHAR_MINUS), "output character is not a digit or minus sign")
    `ASSERT_CLK(a_run_continues, i_clk, i_rst_n, (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |=> o_m_axis_tvalid, "conversion stopped before its last character")
    `ASSERT_CLK(a_empty_accepts, i_clk, i_rst_n, !o_m_axis_tvalid |-> o_s_axis_tready, "input stalled while the output is empty")
    `ASSERT_CLK_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "output valid right after reset")

endmodule
